@@ src/qat_pkg.sv @@
// Package for the quoted argument tokenizer: item, config and command types,
// result kinds and sizing constants. No dependencies.
package qat_pkg;

  localparam int EscRunMax   = 32;
  localparam int EscRunW     = $clog2(EscRunMax + 1);
  localparam int ResCntW     = $clog2(EscRunMax + 4);
  localparam int ArgCntW     = 8;
  localparam logic [ArgCntW-1:0] ArgCountMax = 8'd255;
  localparam int CmdDepth    = 4;
  localparam int CmdPtrW     = $clog2(CmdDepth);

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_ARG_END = 2'd1,
    KIND_STR_END = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_DELIMITER = 3'd0,
    REG_QUOTE     = 3'd1,
    REG_ESCAPE    = 3'd2,
    REG_GATHER    = 3'd3,
    REG_TRIM      = 3'd4,
    REG_KEEP      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
    logic [7:0] escape_char;
    logic       gather_delimiters;
    logic       trim_trailing;
    logic       keep_quotes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    logic [7:0] arg_total;
    logic       escape_overflow;
    logic       last;
  } out_item_t;

  // Results of one request: optional leading entry, an escape run, up to two tail entries.
  typedef struct packed {
    logic [ResCntW-1:0] res_n;
    logic               pre_v;
    kind_e              pre_kind;
    logic [7:0]         pre_ch;
    logic [EscRunW-1:0] esc_n;
    logic [7:0]         esc_ch;
    kind_e              tail0_kind;
    logic [7:0]         tail0_ch;
    kind_e              tail1_kind;
    logic [7:0]         tail1_ch;
    logic [7:0]         total;
    logic               ovf;
  } cmd_t;

endpackage

@@ src/qat_front.sv @@
// Front end: parses one character request per cycle while accept_i is high and builds a result command.
// Depends on qat_pkg.
module qat_front import qat_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_item_t in_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  logic               in_quotes_q, in_quotes_d;
  logic               lookahead_q, lookahead_d;
  logic               lead_held_q, lead_held_d;
  logic               at_start_q, at_start_d;
  logic [EscRunW-1:0] esc_run_q, esc_run_d;
  logic               arg_open_q, arg_open_d;
  logic               after_delim_q, after_delim_d;
  logic [ArgCntW-1:0] arg_cnt_q, arg_cnt_d;
  logic               ovf_q, ovf_d;
  cmd_t               cmd;

  always_comb begin
    kind_e              tk [2];
    logic [7:0]         tc [2];
    logic [1:0]         tn;
    logic               run_go;
    logic [EscRunW-1:0] run_n;
    logic               copy;
    logic               consumed;
    logic               skip;
    logic               is_end;
    logic               c_is_q;
    logic               c_is_d;
    logic               c_is_e;

    in_quotes_d   = in_quotes_q;
    lookahead_d   = lookahead_q;
    lead_held_d   = lead_held_q;
    at_start_d    = at_start_q;
    esc_run_d     = esc_run_q;
    arg_open_d    = arg_open_q;
    after_delim_d = after_delim_q;
    arg_cnt_d     = arg_cnt_q;
    ovf_d         = ovf_q;

    cmd        = '0;
    cmd.esc_ch = cfg_i.escape_char;
    tk[0]      = KIND_CHAR;
    tk[1]      = KIND_CHAR;
    tc[0]      = '0;
    tc[1]      = '0;
    tn         = '0;
    run_go     = 1'b0;
    run_n      = '0;
    copy       = 1'b1;
    consumed   = 1'b0;
    skip       = 1'b0;
    is_end     = in_i.end_of_string;
    c_is_q     = !is_end && (in_i.char_in == cfg_i.quote_char);
    c_is_d     = !is_end && (in_i.char_in == cfg_i.delimiter_char);
    c_is_e     = !is_end && (in_i.char_in == cfg_i.escape_char);

    if (lead_held_d) begin
      lead_held_d = 1'b0;
      in_quotes_d = 1'b1;
      if (is_end) begin
        if (arg_cnt_d < ArgCountMax) arg_cnt_d = arg_cnt_d + 1'b1;
        arg_open_d    = 1'b1;
        after_delim_d = 1'b0;
        if (cfg_i.keep_quotes) begin
          cmd.pre_v    = 1'b1;
          cmd.pre_kind = KIND_CHAR;
          cmd.pre_ch   = cfg_i.quote_char;
        end
      end
    end else if (lookahead_d) begin
      lookahead_d = 1'b0;
      if (c_is_q) begin
        cmd.pre_v    = 1'b1;
        cmd.pre_kind = KIND_CHAR;
        cmd.pre_ch   = cfg_i.quote_char;
        consumed     = 1'b1;
      end else begin
        in_quotes_d = 1'b0;
        if (cfg_i.quote_char == cfg_i.delimiter_char) begin
          cmd.pre_v     = 1'b1;
          cmd.pre_kind  = KIND_ARG_END;
          arg_open_d    = 1'b0;
          after_delim_d = 1'b1;
        end else if (cfg_i.keep_quotes) begin
          cmd.pre_v    = 1'b1;
          cmd.pre_kind = KIND_CHAR;
          cmd.pre_ch   = cfg_i.quote_char;
        end
      end
    end

    if (!consumed && !is_end) begin
      if (at_start_d) begin
        at_start_d = 1'b0;
        if (c_is_q) begin
          lead_held_d = 1'b1;
          skip        = 1'b1;
        end
      end
      if (!skip) begin
        if (esc_run_d != '0) begin
          if (c_is_e) begin
            if (esc_run_d >= EscRunW'(EscRunMax)) begin
              esc_run_d = EscRunW'(EscRunMax - 1);
              ovf_d     = 1'b1;
            end else begin
              esc_run_d = esc_run_d + 1'b1;
            end
          end else begin
            run_go    = 1'b1;
            run_n     = esc_run_d;
            esc_run_d = '0;
          end
        end else if (!(!arg_open_d && after_delim_d && cfg_i.gather_delimiters && c_is_d)) begin
          if (!arg_open_d) begin
            if (arg_cnt_d < ArgCountMax) arg_cnt_d = arg_cnt_d + 1'b1;
            arg_open_d    = 1'b1;
            after_delim_d = 1'b0;
          end
          if (c_is_e) esc_run_d = EscRunW'(1);
          else        run_go    = 1'b1;
        end
      end
      if (run_go) begin
        if (c_is_q && !run_n[0] && in_quotes_d) begin
          cmd.esc_n   = run_n >> 1;
          lookahead_d = 1'b1;
        end else begin
          if (c_is_q) begin
            if (!run_n[0]) begin
              copy        = cfg_i.keep_quotes;
              in_quotes_d = 1'b1;
            end
            run_n = run_n >> 1;
          end
          cmd.esc_n = run_n;
          if (!in_quotes_d && c_is_d) begin
            tk[tn[0]]     = KIND_ARG_END;
            tc[tn[0]]     = '0;
            tn            = tn + 2'd1;
            arg_open_d    = 1'b0;
            after_delim_d = 1'b1;
          end else if (copy) begin
            tk[tn[0]] = KIND_CHAR;
            tc[tn[0]] = in_i.char_in;
            tn        = tn + 2'd1;
          end
        end
      end
    end else if (!consumed) begin
      if (esc_run_d != '0) begin
        cmd.esc_n  = esc_run_d;
        esc_run_d  = '0;
        tk[tn[0]]  = KIND_ARG_END;
        tc[tn[0]]  = '0;
        tn         = tn + 2'd1;
        arg_open_d = 1'b0;
      end else if (arg_open_d) begin
        tk[tn[0]]  = KIND_ARG_END;
        tc[tn[0]]  = '0;
        tn         = tn + 2'd1;
        arg_open_d = 1'b0;
      end else if (after_delim_d && !cfg_i.trim_trailing) begin
        if (arg_cnt_d < ArgCountMax) arg_cnt_d = arg_cnt_d + 1'b1;
        tk[tn[0]] = KIND_ARG_END;
        tc[tn[0]] = '0;
        tn        = tn + 2'd1;
      end
      tk[tn[0]] = KIND_STR_END;
      tc[tn[0]] = '0;
      tn        = tn + 2'd1;
      cmd.total = 8'(arg_cnt_d);
      cmd.ovf   = ovf_d;

      in_quotes_d   = 1'b0;
      lookahead_d   = 1'b0;
      lead_held_d   = 1'b0;
      at_start_d    = 1'b1;
      esc_run_d     = '0;
      arg_open_d    = 1'b0;
      after_delim_d = 1'b0;
      arg_cnt_d     = '0;
      ovf_d         = 1'b0;
    end

    cmd.tail0_kind = tk[0];
    cmd.tail0_ch   = tc[0];
    cmd.tail1_kind = tk[1];
    cmd.tail1_ch   = tc[1];
    cmd.res_n      = ResCntW'(cmd.pre_v) + ResCntW'(cmd.esc_n) + ResCntW'(tn);
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.res_n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q   <= 1'b0;
      lookahead_q   <= 1'b0;
      lead_held_q   <= 1'b0;
      at_start_q    <= 1'b1;
      esc_run_q     <= '0;
      arg_open_q    <= 1'b0;
      after_delim_q <= 1'b0;
      arg_cnt_q     <= '0;
      ovf_q         <= 1'b0;
    end else if (accept_i) begin
      in_quotes_q   <= in_quotes_d;
      lookahead_q   <= lookahead_d;
      lead_held_q   <= lead_held_d;
      at_start_q    <= at_start_d;
      esc_run_q     <= esc_run_d;
      arg_open_q    <= arg_open_d;
      after_delim_q <= after_delim_d;
      arg_cnt_q     <= arg_cnt_d;
      ovf_q         <= ovf_d;
    end
  end

endmodule

@@ src/qat_fifo.sv @@
// Command queue between front end and result expander.
// Depends on qat_pkg.
module qat_fifo import qat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t                 mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CmdPtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (CmdPtrW + 1)'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/qat_back.sv @@
// Back end: walks one queued command, one result per cycle while the output register is free or popped, into it.
// Depends on qat_pkg.
module qat_back import qat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_i,
  output logic      head_pop_o,
  input  logic      out_pop_i,
  output logic      out_valid_o,
  output out_item_t out_o
);

  logic [ResCntW-1:0] pos_q, pos_d;
  logic [ResCntW-1:0] idx;
  logic [ResCntW-1:0] tidx;
  logic               out_valid_q;
  out_item_t          out_q;
  out_item_t          res;
  logic               load;

  always_comb begin
    idx  = pos_q - ResCntW'(head_i.pre_v);
    tidx = idx - ResCntW'(head_i.esc_n);
    res  = '0;
    if (head_i.pre_v && (pos_q == '0)) begin
      res.kind     = head_i.pre_kind;
      res.char_out = head_i.pre_ch;
    end else if (idx < ResCntW'(head_i.esc_n)) begin
      res.kind     = KIND_CHAR;
      res.char_out = head_i.esc_ch;
    end else if (!tidx[0]) begin
      res.kind     = head_i.tail0_kind;
      res.char_out = head_i.tail0_ch;
    end else begin
      res.kind     = head_i.tail1_kind;
      res.char_out = head_i.tail1_ch;
    end
    if (res.kind == KIND_STR_END) begin
      res.arg_total       = head_i.total;
      res.escape_overflow = head_i.ovf;
    end
    res.last = (pos_q == head_i.res_n - 1'b1);
  end

  assign load       = head_valid_i && (!out_valid_q || out_pop_i);
  assign head_pop_o = load && res.last;
  assign pos_d      = load ? (res.last ? '0 : pos_q + 1'b1) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (load)           out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ src/quoted_argument_tokenizer_top.sv @@
// Top level of the quoted argument tokenizer: config registers, front end,
// command queue and result expander. Depends on qat_pkg, qat_front, qat_fifo, qat_back.
//
//   channel   handshake              payload
//   input     push / full            in_data_i  (in_item_t)
//   result    empty / pop            out_data_o (out_item_t)
//   config    cfg_we_i, no wait      cfg_idx_i, cfg_wdata_i
//
// The front end takes one request per cycle while the 4-entry command queue has room.
// The back end sends one result per cycle while results are popped; a request with
// n results holds it for all n, and closing an escape run of length k gives up to k escape characters.
// Requests that give no result (escape inside a run, opening quote) use no back-end slot.
// Reset is asynchronous active low; config returns to its defaults.
module quoted_argument_tokenizer_top import qat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  cfg_idx_e  cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic head_pop;
  logic out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter_char    <= 8'd32;
      cfg_q.quote_char        <= 8'd34;
      cfg_q.escape_char       <= 8'd92;
      cfg_q.gather_delimiters <= 1'b1;
      cfg_q.trim_trailing     <= 1'b1;
      cfg_q.keep_quotes       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELIMITER: cfg_q.delimiter_char    <= cfg_wdata_i;
        REG_QUOTE:     cfg_q.quote_char        <= cfg_wdata_i;
        REG_ESCAPE:    cfg_q.escape_char       <= cfg_wdata_i;
        REG_GATHER:    cfg_q.gather_delimiters <= cfg_wdata_i[0];
        REG_TRIM:      cfg_q.trim_trailing     <= cfg_wdata_i[0];
        REG_KEEP:      cfg_q.keep_quotes       <= cfg_wdata_i[0];
        default:       cfg_q                   <= cfg_q;
      endcase
    end
  end

  assign accept = push && !full;

  qat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  qat_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  qat_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .out_pop_i    (pop && !empty),
    .out_valid_o  (out_valid),
    .out_o        (out_data_o)
  );

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_next_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !out_data_o.last |=> !empty)
    else $error("result sequence broken before its last entry");

  a_str_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_data_o.kind == KIND_STR_END) |-> out_data_o.last)
    else $error("string end is not the last result of its request");

  a_char_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_data_o.kind != KIND_CHAR) |-> (out_data_o.char_out == 8'd0))
    else $error("char_out nonzero on a non-character result");

  a_total_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_data_o.kind != KIND_STR_END)
      |-> (out_data_o.arg_total == 8'd0) && !out_data_o.escape_overflow)
    else $error("string-end fields set on another result");
`endif

endmodule
